>>> rtl/rnr_pkg.sv
// Shared types and constants for the reduced neighbor report parser.
`timescale 1ns / 1ps
`default_nettype none

package rnr_pkg;

    // Record lengths that the parser understands.
    localparam logic [7:0] LEN_SHORT = 8'd7;
    localparam logic [7:0] LEN_FULL  = 8'd16;

    // Byte positions inside a record.
    localparam logic [3:0] POS_OFFSET     = 4'd0;
    localparam logic [3:0] POS_BSSID_LAST = 4'd6;
    localparam logic [3:0] POS_SSID_FIRST = 4'd7;
    localparam logic [3:0] POS_SSID_LAST  = 4'd10;
    localparam logic [3:0] POS_TAIL_FIRST = 4'd11;
    localparam logic [3:0] POS_TAIL_LAST  = 4'd14;
    localparam logic [3:0] POS_FULL_END   = 4'd15;

    // Record status codes carried with each result item.
    typedef enum logic [1:0] {
        ST_SHORT  = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADLEN = 2'd2,
        ST_TRUNC  = 2'd3
    } t_rnr_status;

    // One result item.
    typedef struct packed {
        logic [7:0]  op_class;
        logic [7:0]  chan_num;
        logic [2:0]  hdr_flags;
        logic [7:0]  tbtt_offset;
        logic [47:0] bssid;
        logic [31:0] short_ssid;
        logic [7:0]  bss_params;
        logic [7:0]  psd_limit;
        logic [7:0]  mld_id;
        logic [13:0] mld_link_info;
        t_rnr_status status;
        logic        end_of_element;
    } t_rnr_res;

endpackage

`default_nettype wire

>>> rtl/neighbor_report_parser.sv
// A record result item is registered on acceptance of its last byte, into the output
// register, or the skid stage if output waits; one byte per cycle while tready is high.
// An output register plus a one-entry skid stage keep input flowing while a result waits.
// Input ready drops only while the skid stage holds an item.
// Reset (i_rst_n low, synchronous) returns the parser to the element start and empties
// the output stages.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_report_parser (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  wire  [7:0]    i_s_axis_tdata,   // data_byte[7:0]
    input  wire           i_s_axis_tlast,
    output logic          o_m_axis_tvalid,
    input  wire           i_m_axis_tready,
    // op_class[7:0], chan_num[15:8], hdr_flags[18:16], tbtt_offset[26:19],
    // bssid[74:27], short_ssid[106:75], bss_params[114:107], psd_limit[122:115],
    // mld_id[130:123], mld_link_info[144:131], zero fill[151:145]
    output logic [151:0]  o_m_axis_tdata,
    output logic [1:0]    o_m_axis_tuser,   // status[1:0]
    output logic          o_m_axis_tlast
);
    import rnr_pkg::*;

    logic      accept;
    logic      take;
    logic      res_vld;
    t_rnr_res  res;
    logic      r_ovalid;
    t_rnr_res  r_out;
    logic      r_svalid;
    t_rnr_res  r_skid;

    assign o_s_axis_tready = !r_svalid;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign take            = r_ovalid && i_m_axis_tready;

    rnr_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // Output register and skid stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else if (r_svalid) begin
            if (take || !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_svalid <= 1'b0;
            end
        end else if (accept && res_vld) begin
            if (r_ovalid && !take) begin
                r_svalid <= 1'b1;
            end else begin
                r_ovalid <= 1'b1;
            end
        end else if (take) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output register and skid stage payload.
    always_ff @(posedge i_clk) begin
        if (r_svalid) begin
            if (take || !r_ovalid) begin
                r_out <= r_skid;
            end
        end else if (accept && res_vld) begin
            if (r_ovalid && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    // Pack the result item onto the stream.
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tlast  = r_out.end_of_element;
    assign o_m_axis_tdata  = {7'd0, r_out.mld_link_info, r_out.mld_id, r_out.psd_limit,
                              r_out.bss_params, r_out.short_ssid, r_out.bssid,
                              r_out.tbtt_offset, r_out.hdr_flags, r_out.chan_num,
                              r_out.op_class};

`ifndef SYNTHESIS
    // The skid stage fills only behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svalid |-> r_ovalid)
        else $error("skid stage holds an item while the output register is empty");

    // Every element end yields a result item.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |-> res_vld)
        else $error("element end accepted without a result item");

    // Error statuses are reported only at the element end.
    a_error_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && res_vld && (res.status == ST_BADLEN || res.status == ST_TRUNC))
        |-> i_s_axis_tlast)
        else $error("error status reported before the element end");

    // A stalled skid stage keeps its item while the output register waits.
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_svalid && !take && r_ovalid) |=> r_svalid)
        else $error("skid item lost while output was stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/rnr_parse.sv
// Byte-wise parse state for neighbor AP entries and the result of each byte.
`timescale 1ns / 1ps
`default_nettype none

module rnr_parse (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_accept,
    input  wire  [7:0]         i_byte,
    input  wire                i_last,
    output logic               o_res_vld,
    output rnr_pkg::t_rnr_res  o_res
);
    import rnr_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR_LO = 3'd0,
        PH_HDR_HI = 3'd1,
        PH_CLASS  = 3'd2,
        PH_CHAN   = 3'd3,
        PH_REC    = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [7:0]   r_hdr_lo, n_hdr_lo;
    logic         r_len_bad, n_len_bad;
    logic         r_full, n_full;
    logic [7:0]   r_class, n_class;
    logic [7:0]   r_chan, n_chan;
    logic [4:0]   r_left, n_left;
    logic [3:0]   r_pos, n_pos;
    logic [7:0]   r_offset, n_offset;
    logic [47:0]  r_bssid, n_bssid;
    logic [31:0]  r_ssid, n_ssid;
    logic [31:0]  r_tail, n_tail;
    logic [1:0]   ssid_idx;
    logic [1:0]   tail_idx;
    logic         hi_bad;

    assign ssid_idx = 2'(r_pos - POS_SSID_FIRST);
    assign tail_idx = 2'(r_pos - POS_TAIL_FIRST);
    assign hi_bad   = (i_byte != LEN_SHORT) && (i_byte != LEN_FULL);

    // Next state and the result that this byte produces.
    always_comb begin
        n_phase   = r_phase;
        n_hdr_lo  = r_hdr_lo;
        n_len_bad = r_len_bad;
        n_full    = r_full;
        n_class   = r_class;
        n_chan    = r_chan;
        n_left    = r_left;
        n_pos     = r_pos;
        n_offset  = r_offset;
        n_bssid   = r_bssid;
        n_ssid    = r_ssid;
        n_tail    = r_tail;

        o_res_vld            = 1'b0;
        o_res                = '0;
        o_res.op_class       = r_class;
        o_res.chan_num       = r_chan;
        o_res.hdr_flags      = r_hdr_lo[2:0];
        o_res.status         = ST_TRUNC;
        o_res.end_of_element = i_last;

        unique case (r_phase)
            PH_HDR_LO: begin
                n_hdr_lo        = i_byte;
                n_class         = 8'd0;
                n_chan          = 8'd0;
                n_phase         = PH_HDR_HI;
                o_res_vld       = i_last;
                o_res.op_class  = 8'd0;
                o_res.chan_num  = 8'd0;
                o_res.hdr_flags = i_byte[2:0];
            end
            PH_HDR_HI: begin
                n_len_bad    = hi_bad;
                n_full       = (i_byte == LEN_FULL);
                n_phase      = PH_CLASS;
                o_res_vld    = i_last;
                o_res.status = hi_bad ? ST_BADLEN : ST_TRUNC;
            end
            PH_CLASS: begin
                n_class        = i_byte;
                n_phase        = PH_CHAN;
                o_res_vld      = i_last;
                o_res.op_class = i_byte;
                o_res.status   = r_len_bad ? ST_BADLEN : ST_TRUNC;
            end
            PH_CHAN: begin
                n_chan         = i_byte;
                n_phase        = r_len_bad ? PH_SKIP : PH_REC;
                n_left         = {1'b0, r_hdr_lo[7:4]} + 5'd1;
                n_pos          = 4'd0;
                o_res_vld      = i_last;
                o_res.chan_num = i_byte;
                o_res.status   = r_len_bad ? ST_BADLEN : ST_TRUNC;
            end
            PH_REC: begin
                // Collect the record byte at its position.
                if (r_pos == POS_OFFSET) begin
                    n_offset = i_byte;
                end else if (r_pos <= POS_BSSID_LAST) begin
                    n_bssid = {r_bssid[39:0], i_byte};
                end else if (r_pos <= POS_SSID_LAST) begin
                    n_ssid[8*ssid_idx +: 8] = i_byte;
                end else if (r_pos <= POS_TAIL_LAST) begin
                    n_tail[8*tail_idx +: 8] = i_byte;
                end

                if (r_pos >= (r_full ? POS_FULL_END : POS_BSSID_LAST)) begin
                    // Record finished: report it.
                    n_left            = r_left - 5'd1;
                    n_pos             = 4'd0;
                    o_res_vld         = 1'b1;
                    o_res.tbtt_offset = r_offset;
                    o_res.status      = (i_last && (r_left != 5'd1)) ? ST_TRUNC
                                      : (r_full ? ST_FULL : ST_SHORT);
                    if (r_full) begin
                        o_res.bssid         = r_bssid;
                        o_res.short_ssid    = r_ssid;
                        o_res.bss_params    = r_tail[7:0];
                        o_res.psd_limit     = r_tail[15:8];
                        o_res.mld_id        = r_tail[23:16];
                        o_res.mld_link_info = {i_byte[5:0], r_tail[31:24]};
                    end else begin
                        o_res.bssid = {r_bssid[39:0], i_byte};
                    end
                    if (r_left == 5'd1) begin
                        n_phase = PH_HDR_LO;
                    end
                end else begin
                    n_pos     = r_pos + 4'd1;
                    o_res_vld = i_last;
                end
            end
            PH_SKIP: begin
                o_res_vld    = i_last;
                o_res.status = ST_BADLEN;
            end
            default: begin
                n_phase = PH_HDR_LO;
            end
        endcase

        // The element end always returns to the start of a new element.
        if (i_last) begin
            n_phase = PH_HDR_LO;
            n_pos   = 4'd0;
            n_left  = 5'd0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR_LO;
            r_left    <= 5'd0;
            r_pos     <= 4'd0;
            r_full    <= 1'b0;
            r_len_bad <= 1'b0;
            r_class   <= 8'd0;
            r_chan    <= 8'd0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_full    <= n_full;
            r_len_bad <= n_len_bad;
            r_class   <= n_class;
            r_chan    <= n_chan;
        end
    end

    // Header and record bytes; each is written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr_lo <= n_hdr_lo;
            r_offset <= n_offset;
            r_bssid  <= n_bssid;
            r_ssid   <= n_ssid;
            r_tail   <= n_tail;
        end
    end

endmodule

`default_nettype wire
